/* hw/rtl/mdm_pkg.sv */
package mdm_pkg;

   localparam int FRAC_BITS = 14;

   localparam int AXIS_W = 16;
   localparam int CFG_W  = 15;
   localparam int SUM_W  = AXIS_W + 2;
   localparam int MAG_W  = SUM_W - 1;
   localparam int REM_W  = MAG_W + 1;
   localparam int QUO_W  = FRAC_BITS + 1;
   localparam int LANES  = 4;

   // one restoring step per quotient bit
   localparam int DIV_STEPS = QUO_W;

   localparam logic [MAG_W-1:0] ONE_MAG = MAG_W'(32'd1 << FRAC_BITS);
   localparam logic [CFG_W-1:0] ONE_CFG = CFG_W'(32'd1 << FRAC_BITS);

   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] REG_MOVE_DEADBAND = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_TURN_DEADBAND = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_ARM_SPEED     = 2'd2;

   localparam logic [CFG_W-1:0] MOVE_DEADBAND_RST = 15'd1638;
   localparam logic [CFG_W-1:0] TURN_DEADBAND_RST = 15'd819;
   localparam logic [CFG_W-1:0] ARM_SPEED_RST     = 15'd8192;

   localparam int REQ_DATA_W = 120;
   localparam int RSP_DATA_W = 112;

   typedef struct packed {
      logic [CFG_W-1:0]         pickup;
      logic [CFG_W-1:0]         eject;
      logic signed [AXIS_W-1:0] arm;
   } aux_type;

   typedef struct packed {
      logic              neg;
      logic [AXIS_W-1:0] pass;
      logic [REM_W-1:0]  rem;
      logic [QUO_W-1:0]  quo;
   } lane_type;

   typedef struct packed {
      logic [MAG_W-1:0]    max_mag;
      logic                norm;
      aux_type             aux;
      lane_type [LANES-1:0] lane;
   } div_stage_type;

endpackage

/* hw/rtl/mecanum_drive_mixer_core.sv */
// Mecanum wheel mixer: takes one item per clock and returns one result item per input
// item, in order, after three front stages (deadband/select, mixing and
// largest-magnitude search), fifteen restoring-division stages that produce one quotient
// bit each for all four wheels, and the output register. The whole pipeline holds while
// a result waits on rsp_tready, so req_tready follows rsp_tready when a result is
// pending. Deadband thresholds and arm speed come from the csr_ port; write them only
// while no item is in flight.
module mecanum_drive_mixer_core (
   input  logic                             clock,
   input  logic                             reset,
   // [15:0] op1_strafe, [31:16] op1_forward, [47:32] op1_turn, [63:48] op2_strafe,
   // [79:64] op2_forward, [95:80] op2_turn, [110:96] pickup_trigger,
   // [111] eject_button, [112] raise_button, [113] lower_button, rest zero
   input  logic [mdm_pkg::REQ_DATA_W-1:0]   req_tdata,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // [15:0] left_front_power, [31:16] left_rear_power, [47:32] right_front_power,
   // [63:48] right_rear_power, [78:64] pickup_power, [93:79] eject_power,
   // [109:94] arm_power, rest zero
   output logic [mdm_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   input  logic                             csr_we,
   input  logic [mdm_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [mdm_pkg::CFG_W-1:0]        csr_wdata
);
   import mdm_pkg::*;

   logic [CFG_W-1:0] move_db_ff, move_db_in;
   logic [CFG_W-1:0] turn_db_ff, turn_db_in;
   logic [CFG_W-1:0] arm_speed_ff, arm_speed_in;

   logic                  en;
   logic                  step_valid [DIV_STEPS+1];
   div_stage_type         step_data  [DIV_STEPS+1];

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic signed [AXIS_W-1:0] wheel [LANES];
   logic signed [AXIS_W-1:0] q16;
   div_stage_type         last;

   always_comb begin
      move_db_in   = move_db_ff;
      turn_db_in   = turn_db_ff;
      arm_speed_in = arm_speed_ff;
      if (csr_we) begin
         case (csr_index)
            REG_MOVE_DEADBAND: move_db_in   = csr_wdata;
            REG_TURN_DEADBAND: turn_db_in   = csr_wdata;
            REG_ARM_SPEED:     arm_speed_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         move_db_ff   <= MOVE_DEADBAND_RST;
         turn_db_ff   <= TURN_DEADBAND_RST;
         arm_speed_ff <= ARM_SPEED_RST;
      end else begin
         move_db_ff   <= move_db_in;
         turn_db_ff   <= turn_db_in;
         arm_speed_ff <= arm_speed_in;
      end
   end

   // advance everything unless a result is held
   assign en         = !rsp_valid_ff || rsp_tready;
   assign req_tready = en;

   mdm_front u_front (
      .clock          (clock),
      .reset          (reset),
      .en             (en),
      .in_valid       (req_tvalid),
      .op1_strafe     (req_tdata[15:0]),
      .op1_forward    (req_tdata[31:16]),
      .op1_turn       (req_tdata[47:32]),
      .op2_strafe     (req_tdata[63:48]),
      .op2_forward    (req_tdata[79:64]),
      .op2_turn       (req_tdata[95:80]),
      .pickup_trigger (req_tdata[110:96]),
      .eject_button   (req_tdata[111]),
      .raise_button   (req_tdata[112]),
      .lower_button   (req_tdata[113]),
      .move_deadband  (move_db_ff),
      .turn_deadband  (turn_db_ff),
      .arm_speed      (arm_speed_ff),
      .out_valid      (step_valid[0]),
      .out_data       (step_data[0])
   );

   for (genvar g = 0; g < DIV_STEPS; g++) begin : g_div
      mdm_div_step u_step (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .in_valid  (step_valid[g]),
         .in_data   (step_data[g]),
         .out_valid (step_valid[g+1]),
         .out_data  (step_data[g+1])
      );
   end

   always_comb begin
      last = step_data[DIV_STEPS];
      for (int i = 0; i < LANES; i++) begin
         q16 = {1'b0, last.lane[i].quo};
         if (last.norm) begin
            wheel[i] = last.lane[i].neg ? -q16 : q16;
         end else begin
            wheel[i] = last.lane[i].pass;
         end
      end
      rsp_data_in = {2'b00, last.aux.arm, last.aux.eject, last.aux.pickup,
                     wheel[3], wheel[2], wheel[1], wheel[0]};
      rsp_valid_in = step_valid[DIV_STEPS];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

/* hw/rtl/mdm_front.sv */
module mdm_front (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                en,
   input  logic                                in_valid,
   input  logic signed [mdm_pkg::AXIS_W-1:0]   op1_strafe,
   input  logic signed [mdm_pkg::AXIS_W-1:0]   op1_forward,
   input  logic signed [mdm_pkg::AXIS_W-1:0]   op1_turn,
   input  logic signed [mdm_pkg::AXIS_W-1:0]   op2_strafe,
   input  logic signed [mdm_pkg::AXIS_W-1:0]   op2_forward,
   input  logic signed [mdm_pkg::AXIS_W-1:0]   op2_turn,
   input  logic [mdm_pkg::CFG_W-1:0]           pickup_trigger,
   input  logic                                eject_button,
   input  logic                                raise_button,
   input  logic                                lower_button,
   input  logic [mdm_pkg::CFG_W-1:0]           move_deadband,
   input  logic [mdm_pkg::CFG_W-1:0]           turn_deadband,
   input  logic [mdm_pkg::CFG_W-1:0]           arm_speed,
   output logic                                out_valid,
   output mdm_pkg::div_stage_type              out_data
);
   import mdm_pkg::*;

   function automatic logic in_dead(logic signed [AXIS_W-1:0] v, logic [CFG_W-1:0] t);
      logic signed [AXIS_W:0] vv;
      logic signed [AXIS_W:0] tt;
      vv = {v[AXIS_W-1], v};
      tt = {2'b00, t};
      return (vv < tt) && (vv > -tt);
   endfunction

   // stage 1: deadband and operator select
   logic                      s1_valid_ff, s1_valid_in;
   logic signed [AXIS_W-1:0]  s1_x_ff, s1_y_ff, s1_z_ff;
   logic signed [AXIS_W-1:0]  s1_x_in, s1_y_in, s1_z_in;
   aux_type                   s1_aux_ff, s1_aux_in;

   // stage 2: wheel mix
   logic                      s2_valid_ff, s2_valid_in;
   logic signed [SUM_W-1:0]   s2_p_ff [LANES];
   logic signed [SUM_W-1:0]   s2_p_in [LANES];
   aux_type                   s2_aux_ff, s2_aux_in;

   // stage 3: magnitudes, largest magnitude, divider setup
   logic                      s3_valid_ff, s3_valid_in;
   div_stage_type             s3_data_ff, s3_data_in;

   logic signed [AXIS_W-1:0]  x1, y1, z1;
   logic [CFG_W-1:0]          arm_sat;
   logic signed [SUM_W-1:0]   xe, ye, ze;
   logic [MAG_W-1:0]          mag [LANES];
   logic [MAG_W-1:0]          max_a, max_b, max_all;
   logic signed [SUM_W-1:0]   neg_p;

   always_comb begin
      x1 = in_dead(op1_strafe, move_deadband) ? '0 : op1_strafe;
      y1 = in_dead(op1_forward, move_deadband) ? '0 : op1_forward;
      z1 = in_dead(op1_turn, turn_deadband) ? '0 : op1_turn;
      if (x1 == '0 && y1 == '0 && z1 == '0) begin
         s1_x_in = in_dead(op2_strafe, move_deadband) ? '0 : op2_strafe;
         s1_y_in = in_dead(op2_forward, move_deadband) ? '0 : op2_forward;
         s1_z_in = op2_turn;
      end else begin
         s1_x_in = x1;
         s1_y_in = y1;
         s1_z_in = z1;
      end
      arm_sat = (arm_speed > ONE_CFG) ? ONE_CFG : arm_speed;
      s1_aux_in.pickup = (pickup_trigger > ONE_CFG) ? ONE_CFG : pickup_trigger;
      s1_aux_in.eject  = eject_button ? ONE_CFG : '0;
      if (raise_button) begin
         s1_aux_in.arm = {1'b0, arm_sat};
      end else if (lower_button) begin
         s1_aux_in.arm = -{1'b0, arm_sat};
      end else begin
         s1_aux_in.arm = '0;
      end
      s1_valid_in = in_valid;
   end

   always_comb begin
      xe = {{2{s1_x_ff[AXIS_W-1]}}, s1_x_ff};
      ye = {{2{s1_y_ff[AXIS_W-1]}}, s1_y_ff};
      ze = {{2{s1_z_ff[AXIS_W-1]}}, s1_z_ff};
      s2_p_in[0]  = ye + xe + ze;
      s2_p_in[1]  = ye - xe + ze;
      s2_p_in[2]  = ye - xe - ze;
      s2_p_in[3]  = ye + xe - ze;
      s2_aux_in   = s1_aux_ff;
      s2_valid_in = s1_valid_ff;
   end

   always_comb begin
      for (int i = 0; i < LANES; i++) begin
         neg_p  = -s2_p_ff[i];
         mag[i] = s2_p_ff[i][SUM_W-1] ? neg_p[MAG_W-1:0] : s2_p_ff[i][MAG_W-1:0];
      end
      max_a   = (mag[0] > mag[1]) ? mag[0] : mag[1];
      max_b   = (mag[2] > mag[3]) ? mag[2] : mag[3];
      max_all = (max_a > max_b) ? max_a : max_b;
      s3_data_in.max_mag = max_all;
      s3_data_in.norm    = max_all > ONE_MAG;
      s3_data_in.aux     = s2_aux_ff;
      for (int i = 0; i < LANES; i++) begin
         s3_data_in.lane[i].neg  = s2_p_ff[i][SUM_W-1];
         s3_data_in.lane[i].pass = s2_p_ff[i][AXIS_W-1:0];
         s3_data_in.lane[i].rem  = {1'b0, mag[i]};
         s3_data_in.lane[i].quo  = '0;
      end
      s3_valid_in = s2_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else if (en) begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
         s3_valid_ff <= s3_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_x_ff    <= s1_x_in;
         s1_y_ff    <= s1_y_in;
         s1_z_ff    <= s1_z_in;
         s1_aux_ff  <= s1_aux_in;
         s2_p_ff    <= s2_p_in;
         s2_aux_ff  <= s2_aux_in;
         s3_data_ff <= s3_data_in;
      end
   end

   assign out_valid = s3_valid_ff;
   assign out_data  = s3_data_ff;

endmodule

/* hw/rtl/mdm_div_step.sv */
module mdm_div_step (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   en,
   input  logic                   in_valid,
   input  mdm_pkg::div_stage_type in_data,
   output logic                   out_valid,
   output mdm_pkg::div_stage_type out_data
);
   import mdm_pkg::*;

   logic             valid_ff, valid_in;
   div_stage_type    data_ff, data_in;
   logic [REM_W-1:0] divisor;
   logic [REM_W-1:0] rem_sub;
   logic             ge;

   // one quotient bit per lane: compare, subtract, shift
   always_comb begin
      data_in = in_data;
      divisor = {1'b0, in_data.max_mag};
      for (int i = 0; i < LANES; i++) begin
         ge      = in_data.lane[i].rem >= divisor;
         rem_sub = ge ? (in_data.lane[i].rem - divisor) : in_data.lane[i].rem;
         data_in.lane[i].rem = {rem_sub[REM_W-2:0], 1'b0};
         data_in.lane[i].quo = {in_data.lane[i].quo[QUO_W-2:0], ge};
      end
      valid_in = in_valid;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

/* hw/rtl/mdm_checker.sv */
module mdm_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_tready,
   input logic [mdm_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input logic                           rsp_tvalid,
   input logic                           rsp_tready
);
   import mdm_pkg::*;

   logic signed [AXIS_W-1:0] lf, lr, rf, rr;
   logic [CFG_W-1:0]         eject;

   assign lf    = rsp_tdata[15:0];
   assign lr    = rsp_tdata[31:16];
   assign rf    = rsp_tdata[47:32];
   assign rr    = rsp_tdata[63:48];
   assign eject = rsp_tdata[93:79];

   a_hold_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result dropped while stalled");

   a_hold_data: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata))
      else $error("result changed while stalled");

   a_wheel_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (lf <= 16'sd16384 && lf >= -16'sd16384 &&
                      lr <= 16'sd16384 && lr >= -16'sd16384 &&
                      rf <= 16'sd16384 && rf >= -16'sd16384 &&
                      rr <= 16'sd16384 && rr >= -16'sd16384))
      else $error("wheel power beyond full scale");

   a_eject_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (eject == '0 || eject == ONE_CFG))
      else $error("eject power neither off nor full");

   a_ready_when_free: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("input stalled with no result pending");

endmodule

bind mecanum_drive_mixer_core mdm_checker u_mdm_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready)
);
